// ----- sv/ccfd_pkg.sv -----
// ----------------------------------------------------------------------------
// ccfd_pkg
// Types, constants and CRC helpers shared by the frame deframer.
// ----------------------------------------------------------------------------
package ccfd_pkg;

    localparam logic [7:0]  SYNC_BYTE   = 8'h55;
    localparam logic [7:0]  CRC8_INIT   = 8'hee;
    localparam logic [7:0]  CRC8_POLY   = 8'h31;
    localparam logic [15:0] CRC16_INIT  = 16'h496c;
    localparam logic [15:0] CRC16_POLY  = 16'h1021;
    localparam logic [9:0]  LEN_MASK    = 10'h3ff;
    localparam int          MIN_LEN     = 13;
    localparam int          HDR_BYTES   = 11;
    localparam int          MAX_RESULTS = 64;
    localparam int          QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_PROC,
        ST_EMIT_RD,
        ST_EMIT_PUSH
    } scan_state_t;

    typedef struct packed {
        logic [5:0]  version;
        logic [7:0]  sender;
        logic [7:0]  receiver;
        logic [15:0] sequence_res;
        logic [7:0]  frame_flags;
        logic [7:0]  command_set;
        logic [7:0]  command_id;
        logic [5:0]  payload_length;
        logic [7:0]  payload_byte;
        logic        last_of_frame;
    } result_t;

    function automatic logic [7:0] rev8(input logic [7:0] x);
        logic [7:0] r;
        for (int k = 0; k < 8; k++)
        begin
            r[k] = x[7-k];
        end
        return r;
    endfunction

    function automatic logic [15:0] rev16(input logic [15:0] x);
        logic [15:0] r;
        for (int k = 0; k < 16; k++)
        begin
            r[k] = x[15-k];
        end
        return r;
    endfunction

    function automatic logic [7:0] crc8_byte(input logic [7:0] v, input logic [7:0] b);
        logic [7:0] c;
        c = v ^ rev8(b);
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC8_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_byte(input logic [15:0] v, input logic [7:0] b);
        logic [15:0] c;
        c = v ^ {rev8(b), 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC16_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- sv/ccfd_if.sv -----
// ----------------------------------------------------------------------------
// ccfd_if
// Valid/ready channels: received bytes in, decoded frame results out.
// ----------------------------------------------------------------------------
interface ccfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface ccfd_frame_if;
    logic        valid;
    logic        ready;
    logic [5:0]  version;
    logic [7:0]  sender;
    logic [7:0]  receiver;
    logic [15:0] sequence_res;
    logic [7:0]  frame_flags;
    logic [7:0]  command_set;
    logic [7:0]  command_id;
    logic [5:0]  payload_length;
    logic [7:0]  payload_byte;
    logic        last_of_frame;

    modport source (output valid, output version, output sender, output receiver,
                    output sequence_res, output frame_flags, output command_set,
                    output command_id, output payload_length, output payload_byte,
                    output last_of_frame, input ready);
    modport sink (input valid, input version, input sender, input receiver,
                  input sequence_res, input frame_flags, input command_set,
                  input command_id, input payload_length, input payload_byte,
                  input last_of_frame, output ready);
endinterface

// ----- sv/ccfd_front.sv -----
// ----------------------------------------------------------------------------
// ccfd_front
// Byte store and frame scanner: checks sync, header CRC, length and body
// CRC, and pushes one result per payload byte of each good frame (one result for an empty payload).
// ----------------------------------------------------------------------------
module ccfd_front
    import ccfd_pkg::*;
#(
    parameter int FRAME_MAX = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        push,
    output result_t     push_data,
    input  logic        q_full
);

    localparam int AW = $clog2(FRAME_MAX);
    localparam int IW = $clog2(FRAME_MAX + 1);

    logic [7:0]   mem [FRAME_MAX];
    logic [7:0]   rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    scan_state_t  state_reg, state_next;
    logic [AW-1:0] head_reg;
    logic [IW-1:0] fill_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] k_reg;
    logic [7:0]   crc8_reg;
    logic [15:0]  crc16_reg;
    logic [15:0]  word_reg;
    logic [7:0]   crc_lo_reg;
    logic [6:0]   res_cnt_reg;
    logic [7:0]   sender_reg, receiver_reg, flags_reg, cset_reg, cid_reg;
    logic [15:0]  seq_reg;

    logic [9:0]   len10;
    logic         len_ok;
    logic [IW-1:0] len_i;
    logic [IW-1:0] plen;
    logic [IW-1:0] runs;
    logic         last_run;
    logic         cap_ok;
    logic         accept;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [IW-1:0] off);
        logic [IW:0] s;
        s = (IW+1)'(base) + (IW+1)'(off);
        if (s >= (IW+1)'(FRAME_MAX))
        begin
            s = s - (IW+1)'(FRAME_MAX);
        end
        return AW'(s);
    endfunction

    assign len10    = word_reg[9:0] & LEN_MASK;
    assign len_ok   = (len10 >= 10'(MIN_LEN)) && (len10 <= 10'(FRAME_MAX));
    assign len_i    = IW'(len10);
    assign plen     = len_i - IW'(MIN_LEN);
    assign runs     = (plen == '0) ? IW'(1) : plen;
    assign last_run = (k_reg == runs - IW'(1));
    assign cap_ok   = (res_cnt_reg < 7'(MAX_RESULTS));
    assign accept   = in_valid && in_ready;
    assign wr_addr  = wrap_add(head_reg, fill_reg);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem[wr_addr] <= in_byte;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_PROC;
            end
            ST_PROC:
            begin
                state_next = ST_RD;
                priority if (idx_reg == '0 && rd_data_reg != SYNC_BYTE)
                begin
                    if (fill_reg == IW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (idx_reg == IW'(3) && (crc8_reg != rev8(rd_data_reg) || !len_ok))
                begin
                    if (fill_reg == IW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (idx_reg >= IW'(4) && idx_reg == len_i - IW'(1))
                begin
                    if ({rd_data_reg, crc_lo_reg} == rev16(crc16_reg))
                    begin
                        state_next = ST_EMIT_RD;
                    end
                    else if (fill_reg == IW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    if (idx_reg + IW'(1) >= fill_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_PUSH;
            end
            ST_EMIT_PUSH:
            begin
                if (!(q_full && cap_ok))
                begin
                    if (!last_run)
                    begin
                        state_next = ST_EMIT_RD;
                    end
                    else if (fill_reg == len_i)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        push     = 1'b0;
        rd_addr  = wrap_add(head_reg, idx_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_EMIT_RD:
            begin
                rd_addr = wrap_add(head_reg, IW'(HDR_BYTES) + k_reg);
            end
            ST_EMIT_PUSH:
            begin
                rd_addr = wrap_add(head_reg, IW'(HDR_BYTES) + k_reg);
                push    = cap_ok && !q_full;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        push_data.version        = word_reg[15:10];
        push_data.sender         = sender_reg;
        push_data.receiver       = receiver_reg;
        push_data.sequence_res   = seq_reg;
        push_data.frame_flags    = flags_reg;
        push_data.command_set    = cset_reg;
        push_data.command_id     = cid_reg;
        push_data.payload_length = 6'(plen);
        push_data.payload_byte   = (plen == '0) ? 8'h00 : rd_data_reg;
        push_data.last_of_frame  = last_run;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            fill_reg    <= '0;
            idx_reg     <= '0;
            k_reg       <= '0;
            res_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        idx_reg     <= '0;
                        res_cnt_reg <= '0;
                        if (fill_reg == IW'(FRAME_MAX))
                        begin
                            head_reg <= wrap_add(head_reg, IW'(1));
                        end
                        else
                        begin
                            fill_reg <= fill_reg + IW'(1);
                        end
                    end
                end
                ST_PROC:
                begin
                    if (state_next == ST_EMIT_RD)
                    begin
                        k_reg <= '0;
                    end
                    else if (state_next == ST_IDLE && idx_reg + IW'(1) >= fill_reg
                             && fill_reg != IW'(1))
                    begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                    else if ((idx_reg == '0 && rd_data_reg != SYNC_BYTE)
                             || (idx_reg == IW'(3)
                                 && (crc8_reg != rev8(rd_data_reg) || !len_ok))
                             || (idx_reg >= IW'(4) && idx_reg == len_i - IW'(1)))
                    begin
                        head_reg <= wrap_add(head_reg, IW'(1));
                        fill_reg <= fill_reg - IW'(1);
                        idx_reg  <= '0;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                end
                ST_EMIT_PUSH:
                begin
                    if (!(q_full && cap_ok))
                    begin
                        if (cap_ok)
                        begin
                            res_cnt_reg <= res_cnt_reg + 7'd1;
                        end
                        if (last_run)
                        begin
                            head_reg <= wrap_add(head_reg, len_i);
                            fill_reg <= fill_reg - len_i;
                            idx_reg  <= '0;
                        end
                        else
                        begin
                            k_reg <= k_reg + IW'(1);
                        end
                    end
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PROC)
        begin
            if (idx_reg == '0)
            begin
                crc8_reg  <= crc8_byte(CRC8_INIT, rd_data_reg);
                crc16_reg <= crc16_byte(CRC16_INIT, rd_data_reg);
            end
            else if (idx_reg < IW'(3))
            begin
                crc8_reg  <= crc8_byte(crc8_reg, rd_data_reg);
                crc16_reg <= crc16_byte(crc16_reg, rd_data_reg);
            end
            else if (idx_reg < len_i - IW'(2))
            begin
                crc16_reg <= crc16_byte(crc16_reg, rd_data_reg);
            end
            if (idx_reg == IW'(1))
            begin
                word_reg[7:0] <= rd_data_reg;
            end
            if (idx_reg == IW'(2))
            begin
                word_reg[15:8] <= rd_data_reg;
            end
            if (idx_reg == IW'(4))
            begin
                sender_reg <= rd_data_reg;
            end
            if (idx_reg == IW'(5))
            begin
                receiver_reg <= rd_data_reg;
            end
            if (idx_reg == IW'(6))
            begin
                seq_reg[7:0] <= rd_data_reg;
            end
            if (idx_reg == IW'(7))
            begin
                seq_reg[15:8] <= rd_data_reg;
            end
            if (idx_reg == IW'(8))
            begin
                flags_reg <= rd_data_reg;
            end
            if (idx_reg == IW'(9))
            begin
                cset_reg <= rd_data_reg;
            end
            if (idx_reg == IW'(10))
            begin
                cid_reg <= rd_data_reg;
            end
            if (idx_reg >= IW'(4) && idx_reg == len_i - IW'(2))
            begin
                crc_lo_reg <= rd_data_reg;
            end
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= IW'(FRAME_MAX))
        else $error("fill level above store depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg < AW'(FRAME_MAX - 1) || head_reg == AW'(FRAME_MAX - 1))
        else $error("head pointer out of range");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full && res_cnt_reg < 7'(MAX_RESULTS))
        else $error("push into full queue or past result limit");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input taken while scan pending");

endmodule

// ----- sv/ccfd_queue.sv -----
// ----------------------------------------------------------------------------
// ccfd_queue
// Short result FIFO between the scanner and the output stage.
// ----------------------------------------------------------------------------
module ccfd_queue
    import ccfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    not_empty,
    output result_t pop_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    result_t         slot [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     count_reg;

    assign full      = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + (PW+1)'(1);
                2'b01:   count_reg <= count_reg - (PW+1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |-> !push)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue underflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PW+1)'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// ----- sv/ccfd_back.sv -----
// ----------------------------------------------------------------------------
// ccfd_back
// Output register: takes results from the queue and holds each transfer
// until the sink is ready.
// ----------------------------------------------------------------------------
module ccfd_back
    import ccfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_not_empty,
    input  result_t q_data,
    output logic    pop,
    ccfd_frame_if.source out
);

    logic    valid_reg;
    result_t data_reg;

    assign pop = q_not_empty && (!valid_reg || out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || out.ready)
        begin
            valid_reg <= q_not_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= q_data;
        end
    end

    assign out.valid          = valid_reg;
    assign out.version        = data_reg.version;
    assign out.sender         = data_reg.sender;
    assign out.receiver       = data_reg.receiver;
    assign out.sequence_res   = data_reg.sequence_res;
    assign out.frame_flags    = data_reg.frame_flags;
    assign out.command_set    = data_reg.command_set;
    assign out.command_id     = data_reg.command_id;
    assign out.payload_length = data_reg.payload_length;
    assign out.payload_byte   = data_reg.payload_byte;
    assign out.last_of_frame  = data_reg.last_of_frame;

endmodule

// ----- sv/crc_checked_frame_deframer.sv -----
// A byte is taken only while the scanner is idle; each scanned byte then costs a
// store read and a check, and each result of a good frame a store read and a push,
// which waits while the queue is full.
// No new byte is taken until the scan of the store is through.
// Results pass from the scanner's push through the queue and the output register to the port.
// Reset (rst_n, async): store empty, queue emptied and output valid cleared.
// ----------------------------------------------------------------------------
// crc_checked_frame_deframer
// Top level: byte store and scanner, result queue, output register.
// ----------------------------------------------------------------------------
module crc_checked_frame_deframer
    import ccfd_pkg::*;
#(
    parameter int FRAME_MAX = 64
)
(
    input  logic clk,
    input  logic rst_n,
    ccfd_byte_if.sink    in,
    ccfd_frame_if.source out
);

    logic    push;
    result_t push_data;
    logic    q_full;
    logic    pop;
    logic    q_not_empty;
    result_t q_data;

    ccfd_front #(
        .FRAME_MAX (FRAME_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in.valid),
        .in_ready  (in.ready),
        .in_byte   (in.data_byte),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    ccfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    ccfd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_data),
        .pop         (pop),
        .out         (out)
    );

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives link bytes into the frame deframer and checks every decoded result
// against a behavioral model of the frame store, header CRC-8 and body CRC-16.
// ----------------------------------------------------------------------------
module testbench
    import ccfd_pkg::*;
();

    localparam int FMAX = 64;
    localparam int WATCHDOG = 50000;

    logic clk;
    logic rst_n;

    ccfd_byte_if  byte_ch ();
    ccfd_frame_if frame_ch ();

    crc_checked_frame_deframer #(.FRAME_MAX(FMAX)) dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (byte_ch.sink),
        .out   (frame_ch.source)
    );

    logic [7:0] store_bytes [FMAX];
    int         store_fill = 0;
    int         good_frames = 0;
    int         bad_frames = 0;

    logic [7:0] pending_bytes [$];
    result_t    expected_results [$];
    int         error_count = 0;
    int         result_count = 0;
    int         idle_cycles;
    int         hold_off;
    int         tx_gap;
    int         rx_gap;
    bit         hold_req = 1'b0;
    bit         hold_taken;
    bit         drain_wait;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic logic [7:0] bit_rev8(input logic [7:0] x);
        logic [7:0] r;
        for (int k = 0; k < 8; k++)
        begin
            r[k] = x[7-k];
        end
        return r;
    endfunction

    function automatic logic [7:0] header_crc(input logic [7:0] b0, input logic [7:0] b1,
                                              input logic [7:0] b2);
        logic [7:0] v;
        logic [7:0] bytes [3];
        bytes[0] = b0;
        bytes[1] = b1;
        bytes[2] = b2;
        v = 8'hee;
        for (int i = 0; i < 3; i++)
        begin
            v ^= bit_rev8(bytes[i]);
            for (int b = 0; b < 8; b++)
            begin
                v = v[7] ? ({v[6:0], 1'b0} ^ 8'h31) : {v[6:0], 1'b0};
            end
        end
        return bit_rev8(v);
    endfunction

    function automatic logic [15:0] body_crc(input logic [7:0] bytes [$], input int n);
        logic [15:0] v;
        logic [15:0] r;
        v = 16'h496c;
        for (int i = 0; i < n; i++)
        begin
            v ^= {bit_rev8(bytes[i]), 8'h00};
            for (int b = 0; b < 8; b++)
            begin
                v = v[15] ? ({v[14:0], 1'b0} ^ 16'h1021) : {v[14:0], 1'b0};
            end
        end
        for (int k = 0; k < 16; k++)
        begin
            r[k] = v[15-k];
        end
        return r;
    endfunction

    function automatic void store_shift(input int k);
        for (int i = 0; i + k < store_fill; i++)
        begin
            store_bytes[i] = store_bytes[i+k];
        end
        store_fill -= k;
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        logic [7:0] q [$];
        logic [15:0] word;
        int len;
        int plen;
        int runs;
        result_t r;
        if (store_fill >= FMAX)
        begin
            store_shift(1);
        end
        store_bytes[store_fill] = b;
        store_fill++;
        while (store_fill > 0)
        begin
            if (store_bytes[0] != SYNC_BYTE)
            begin
                store_shift(1);
                continue;
            end
            if (store_fill < 4)
            begin
                break;
            end
            if (header_crc(store_bytes[0], store_bytes[1], store_bytes[2]) != store_bytes[3])
            begin
                store_shift(1);
                bad_frames++;
                continue;
            end
            word = {store_bytes[2], store_bytes[1]};
            len = int'(word[9:0]);
            if (len < MIN_LEN || len > FMAX)
            begin
                store_shift(1);
                bad_frames++;
                continue;
            end
            if (store_fill < len)
            begin
                break;
            end
            q.delete();
            for (int i = 0; i < len - 2; i++)
            begin
                q.push_back(store_bytes[i]);
            end
            if (body_crc(q, len - 2) != {store_bytes[len-1], store_bytes[len-2]})
            begin
                store_shift(1);
                bad_frames++;
                continue;
            end
            good_frames++;
            plen = len - MIN_LEN;
            runs = (plen != 0) ? plen : 1;
            for (int k = 0; k < runs; k++)
            begin
                r.version        = word[15:10];
                r.sender         = store_bytes[4];
                r.receiver       = store_bytes[5];
                r.sequence_res   = {store_bytes[7], store_bytes[6]};
                r.frame_flags    = store_bytes[8];
                r.command_set    = store_bytes[9];
                r.command_id     = store_bytes[10];
                r.payload_length = plen[5:0];
                r.payload_byte   = (plen != 0) ? store_bytes[11+k] : 8'h00;
                r.last_of_frame  = (k + 1 == runs);
                expected_results.push_back(r);
            end
            store_shift(len);
        end
    endfunction

    task automatic queue_frame(input int plen, input int version, input int fault);
        logic [7:0] f [$];
        logic [15:0] word;
        logic [15:0] c;
        int len;
        len = plen + MIN_LEN;
        word = {version[5:0], len[9:0]};
        if (fault == 2)
        begin
            word[9:0] = ($urandom_range(1) != 0) ? 10'($urandom_range(12)) :
                        10'($urandom_range(1023, FMAX + 1));
        end
        f.push_back(SYNC_BYTE);
        f.push_back(word[7:0]);
        f.push_back(word[15:8]);
        f.push_back(header_crc(SYNC_BYTE, word[7:0], word[15:8]));
        if (fault == 1)
        begin
            f[3] ^= 8'(1 << $urandom_range(7));
        end
        for (int i = 4; i < len - 2; i++)
        begin
            f.push_back(8'($urandom));
        end
        c = body_crc(f, len - 2);
        if (fault == 3)
        begin
            c ^= 16'(1 << $urandom_range(15));
        end
        f.push_back(c[7:0]);
        f.push_back(c[15:8]);
        foreach (f[i])
        begin
            pending_bytes.push_back(f[i]);
        end
    endtask

    task automatic queue_directed_frame(input int plen, input logic [7:0] fill);
        logic [7:0] f [$];
        logic [15:0] word;
        logic [15:0] c;
        int len;
        len = plen + MIN_LEN;
        word = {6'h3f, len[9:0]};
        f.push_back(SYNC_BYTE);
        f.push_back(word[7:0]);
        f.push_back(word[15:8]);
        f.push_back(header_crc(SYNC_BYTE, word[7:0], word[15:8]));
        for (int i = 4; i < len - 2; i++)
        begin
            f.push_back(fill);
        end
        c = body_crc(f, len - 2);
        f.push_back(c[7:0]);
        f.push_back(c[15:8]);
        foreach (f[i])
        begin
            pending_bytes.push_back(f[i]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_ch.valid     <= 1'b0;
            byte_ch.data_byte <= 8'h00;
            tx_gap            <= 0;
        end
        else if (!byte_ch.valid || byte_ch.ready)
        begin
            if (byte_ch.valid)
            begin
                deframe_byte(byte_ch.data_byte);
            end
            if (tx_gap > 0 || drain_wait)
            begin
                byte_ch.valid <= 1'b0;
                tx_gap <= (tx_gap > 0) ? tx_gap - 1 : 0;
            end
            else if (pending_bytes.size() > 0)
            begin
                byte_ch.valid     <= 1'b1;
                byte_ch.data_byte <= pending_bytes.pop_front();
                tx_gap <= ($urandom_range(9) < 6) ? 0 :
                          ($urandom_range(15) == 0) ? $urandom_range(80, 20) :
                          $urandom_range(4, 1);
            end
            else
            begin
                byte_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_ch.ready <= 1'b0;
            rx_gap         <= 0;
            hold_off       <= 0;
            hold_taken     <= 1'b0;
        end
        else if (hold_req && !hold_taken)
        begin
            frame_ch.ready <= 1'b0;
            hold_off       <= 400;
            hold_taken     <= 1'b1;
        end
        else if (hold_off > 0)
        begin
            frame_ch.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else if (rx_gap > 0)
        begin
            frame_ch.ready <= 1'b0;
            rx_gap <= rx_gap - 1;
        end
        else
        begin
            frame_ch.ready <= 1'b1;
            rx_gap <= ($urandom_range(9) < 7) ? 0 :
                      ($urandom_range(15) == 0) ? $urandom_range(60, 15) :
                      $urandom_range(3, 1);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && frame_ch.valid && frame_ch.ready)
        begin
            result_t got;
            result_t want;
            got.version        = frame_ch.version;
            got.sender         = frame_ch.sender;
            got.receiver       = frame_ch.receiver;
            got.sequence_res   = frame_ch.sequence_res;
            got.frame_flags    = frame_ch.frame_flags;
            got.command_set    = frame_ch.command_set;
            got.command_id     = frame_ch.command_id;
            got.payload_length = frame_ch.payload_length;
            got.payload_byte   = frame_ch.payload_byte;
            got.last_of_frame  = frame_ch.last_of_frame;
            result_count++;
            if (expected_results.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %h", $time, got);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    $display("%0t mismatch: expected %h, actual %h", $time, want, got);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (byte_ch.valid && byte_ch.ready) || (frame_ch.valid && frame_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (rst_n && idle_cycles >= WATCHDOG)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int kind;
        rst_n = 1'b0;
        drain_wait = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: min and max frames, bad header, bad length, bad body, noise
        queue_directed_frame(0, 8'h00);
        queue_directed_frame(FMAX - MIN_LEN, 8'hff);
        queue_frame(2, 0, 1);
        queue_frame(2, 5, 2);
        queue_frame(3, 9, 3);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hff);
        pending_bytes.push_back(SYNC_BYTE);
        queue_frame(0, 63, 0);

        // receiver holds off while the sender keeps offering frames
        @(posedge clk);
        hold_req = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            queue_frame($urandom_range(6), $urandom_range(63), 0);
        end
        wait (pending_bytes.size() == 0);
        drain_wait = 1'b1;
        wait (expected_results.size() == 0 && hold_taken && hold_off == 0);
        repeat (300) @(posedge clk);
        drain_wait = 1'b0;

        while (pending_bytes.size() < 120)
        begin
            kind = $urandom_range(9);
            if (kind < 6)
            begin
                queue_frame(($urandom_range(7) == 0) ? $urandom_range(FMAX - MIN_LEN) :
                            $urandom_range(4), $urandom_range(63), 0);
            end
            else if (kind < 9)
            begin
                queue_frame($urandom_range(4), $urandom_range(63), kind - 5);
            end
            else
            begin
                repeat ($urandom_range(6, 1))
                begin
                    pending_bytes.push_back(($urandom_range(3) == 0) ? SYNC_BYTE : 8'($urandom));
                end
            end
        end
        // flush any partial frame left in the store with trailing good frames
        for (int i = 0; i < 3; i++)
        begin
            queue_frame(0, $urandom_range(63), 0);
        end
        wait (pending_bytes.size() == 0 && !byte_ch.valid);
        wait (expected_results.size() == 0);
        repeat (300) @(posedge clk);

        $display("run: %0d results checked, %0d good frames, %0d rejected frame starts",
                 result_count, good_frames, bad_frames);
        if (error_count == 0 && expected_results.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
